/* rtl/rtc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types and constants for the textured wall column renderer.
// ----------------------------------------------------------------------------
package rtc_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_H,
        S_SETUP,
        S_DIV_S,
        S_POS,
        S_ACTIVE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic start_capture;
        logic div_h_start;
        logic setup;
        logic div_s_start;
        logic pos;
        logic tick;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic height_zero;
        logic last;
    } t_status;

    localparam logic [1:0] REG_CEIL  = 2'd0;
    localparam logic [1:0] REG_FLOOR = 2'd1;

endpackage
`default_nettype wire

/* rtl/rtc_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_div
// Restoring divider, one quotient bit per cycle, 32-bit operands.
// ----------------------------------------------------------------------------
module rtc_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_quot
);
    logic [31:0] r_quot, n_quot;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [32:0] w_trial;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_trial = {r_rem[31:0], r_quot[31]};
        if (i_start) begin
            n_quot = i_num;
            n_rem  = '0;
            n_cnt  = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem  = w_trial - {1'b0, r_den};
                n_quot = {r_quot[30:0], 1'b1};
            end else begin
                n_rem  = w_trial;
                n_quot = {r_quot[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_busy && (r_cnt == 6'd1);
    assign o_quot = n_quot;
endmodule
`default_nettype wire

/* rtl/rtc_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_ctrl
// Sequencer for column setup and pixel ticks.
// ----------------------------------------------------------------------------
module rtc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic [1:0]      i_action,
    input  wire rtc_pkg::t_status i_status,
    input  wire logic            i_out_free,
    output logic                 o_in_stall,
    output rtc_pkg::t_cmd        o_cmd
);
    import rtc_pkg::*;

    t_state r_state, n_state;
    t_action w_act;
    logic w_acc;

    assign w_act = t_action'(i_action);

    always_comb begin
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE:   o_in_stall = 1'b0;
            S_ACTIVE: o_in_stall = (w_act == ACT_TICK) && !i_out_free;
            default:  o_in_stall = 1'b1;
        endcase
    end

    assign w_acc = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE, S_ACTIVE: begin
                if (w_acc && w_act == ACT_START) n_state = S_DIV_H;
                else if (w_acc && w_act == ACT_TICK && r_state == S_ACTIVE
                         && i_status.last) n_state = S_IDLE;
            end
            S_DIV_H: if (i_status.div_done) n_state = S_SETUP;
            S_SETUP: n_state = i_status.height_zero ? S_ACTIVE : S_DIV_S;
            S_DIV_S: if (i_status.div_done) n_state = S_POS;
            S_POS:   n_state = S_ACTIVE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE, S_ACTIVE: begin
                o_cmd.start_capture = w_acc && w_act == ACT_START;
                o_cmd.div_h_start   = w_acc && w_act == ACT_START;
                o_cmd.tick = w_acc && w_act == ACT_TICK && r_state == S_ACTIVE;
            end
            S_SETUP: begin
                o_cmd.setup       = 1'b1;
                o_cmd.div_s_start = !i_status.height_zero;
            end
            S_POS:   o_cmd.pos = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule
`default_nettype wire

/* rtl/rtc_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_dp
// Column geometry, texture memory and pixel output register.
// ----------------------------------------------------------------------------
module rtc_dp #(
    parameter int SCREEN_HEIGHT = 512,
    parameter int TEX_SIZE      = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rtc_pkg::t_cmd   i_cmd,
    input  wire logic            i_in_accept,
    input  wire logic [1:0]      i_action,
    input  wire logic [9:0]      i_column,
    input  wire logic [15:0]     i_distance,
    input  wire logic signed [15:0] i_ray_x,
    input  wire logic signed [15:0] i_ray_y,
    input  wire logic [15:0]     i_pos_x,
    input  wire logic [15:0]     i_pos_y,
    input  wire logic            i_side,
    input  wire logic [1:0]      i_tex_select,
    input  wire logic [11:0]     i_tex_addr,
    input  wire logic [23:0]     i_texel,
    input  wire logic [23:0]     i_ceiling_color,
    input  wire logic [23:0]     i_floor_color,
    input  wire logic            i_out_stall,
    output rtc_pkg::t_status     o_status,
    output logic                 o_out_free,
    output logic                 o_out_valid,
    output logic [8:0]           o_row,
    output logic [9:0]           o_pixel_column,
    output logic [23:0]          o_color,
    output logic                 o_last
);
    import rtc_pkg::*;

    localparam int TB   = $clog2(TEX_SIZE);
    localparam int HALF = SCREEN_HEIGHT / 2;
    localparam logic [31:0] HNUM = 32'(HALF * 256 * 135);
    localparam logic [9:0] HALF10 = 10'(HALF);
    localparam logic [9:0] LASTR  = 10'(SCREEN_HEIGHT - 1);

    logic [23:0] r_mem [0:16383];
    logic [15:0] r_dist;
    logic signed [15:0] r_rx, r_ry;
    logic [15:0] r_px, r_py;
    logic        r_side;
    logic [31:0] r_height, r_step, r_tpos;
    logic [9:0]  r_top, r_bot, r_row, r_col;
    logic [5:0]  r_tcol;
    logic [1:0]  r_tch;
    logic        r_ovalid;
    logic [8:0]  r_orow;
    logic [9:0]  r_ocol;
    logic [1:0]  r_osrc;
    logic [23:0] r_rd;
    logic        r_olast;

    logic        w_dstart;
    logic [31:0] w_num, w_den, w_quot;
    logic        w_ddone;

    assign w_dstart = i_cmd.div_h_start || i_cmd.div_s_start;
    assign w_num = i_cmd.div_h_start ? HNUM : 32'(TEX_SIZE << 16);
    assign w_den = i_cmd.div_h_start
                   ? 32'(7'd100 * ((i_distance == 16'd0) ? 16'd1 : i_distance))
                   : r_height;

    rtc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_num), .i_den(w_den), .o_done(w_ddone), .o_quot(w_quot)
    );

    // setup geometry
    logic [31:0] w_hh;
    logic [9:0]  w_top, w_bot;
    logic signed [35:0] w_hit;
    logic [19:0] w_frac;
    logic [TB-1:0] w_tx;
    logic        w_mirror;
    logic [15:0] w_d1;

    always_comb begin
        w_hh  = r_height >> 1;
        w_top = (w_hh >= 32'(HALF)) ? 10'd0 : HALF10 - w_hh[9:0];
        w_bot = (w_hh >= 32'(SCREEN_HEIGHT - 1 - HALF)) ? LASTR : HALF10 + w_hh[9:0];
        w_d1  = (r_dist == 16'd0) ? 16'd1 : r_dist;
        if (!r_side)
            w_hit = $signed({8'd0, r_py, 12'd0}) + $signed({1'b0, w_d1}) * r_ry;
        else
            w_hit = $signed({8'd0, r_px, 12'd0}) + $signed({1'b0, w_d1}) * r_rx;
        w_frac = w_hit[19:0];
        w_tx   = w_frac[19 -: TB];
        w_mirror = (!r_side && r_rx > 0) || (r_side && r_ry < 0);
        if (w_mirror) w_tx = ~w_tx;
    end

    // pixel path
    logic [TB-1:0] w_ty;
    logic [13:0]   w_addr;
    logic          w_wall;
    assign w_ty   = r_tpos[16 +: TB];
    assign w_wall = (r_row >= r_top) && (r_row < r_bot);
    assign w_addr = {r_tch, 12'({w_ty, r_tcol[TB-1:0]})};

    always_ff @(posedge i_clk) begin
        if (i_in_accept && t_action'(i_action) == ACT_LOAD)
            r_mem[{i_tex_select, i_tex_addr}] <= i_texel;
        if (i_cmd.tick) r_rd <= r_mem[w_addr];
    end

    assign o_out_free = !r_ovalid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_row <= '0; r_top <= '0; r_bot <= '0;
            r_step <= '0; r_tpos <= '0;
        end else begin
            if (i_cmd.tick) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
            if (i_cmd.start_capture) r_row <= '0;
            else if (i_cmd.tick) r_row <= r_row + 10'd1;
            if (i_cmd.setup) begin
                r_top <= w_top; r_bot <= w_bot;
                r_step <= '0; r_tpos <= '0;
            end
            if (w_ddone && r_height != 0 && !i_cmd.div_h_start) r_step <= w_quot;
            // rows of the wall hidden above the screen, times the step
            if (i_cmd.pos)
                r_tpos <= (32'(r_top) - 32'(HALF) + w_hh) * r_step;
            else if (i_cmd.tick && w_wall) r_tpos <= r_tpos + r_step;
        end
        if (i_cmd.start_capture) begin
            r_dist <= i_distance; r_rx <= i_ray_x; r_ry <= i_ray_y;
            r_px <= i_pos_x; r_py <= i_pos_y; r_side <= i_side;
            r_col <= i_column; r_height <= '1;
        end
        if (w_ddone && r_height == 32'hFFFF_FFFF) r_height <= w_quot;
        if (i_cmd.setup) begin
            r_tcol <= 6'(w_tx);
            r_tch  <= r_side ? {1'b0, r_ry < 0} : {1'b1, r_rx < 0};
        end
        if (i_cmd.tick) begin
            r_orow  <= r_row[8:0];
            r_ocol  <= r_col;
            r_osrc  <= (r_row < r_top) ? 2'd0 : (w_wall ? 2'd1 : 2'd2);
            r_olast <= r_row >= LASTR;
        end
    end

    assign o_status.div_done    = w_ddone;
    assign o_status.height_zero = (r_height == 32'd0);
    assign o_status.last        = r_row >= LASTR;

    assign o_out_valid    = r_ovalid;
    assign o_row          = r_orow;
    assign o_pixel_column = r_ocol;
    assign o_color = (r_osrc == 2'd0) ? i_ceiling_color :
                     (r_osrc == 2'd1) ? r_rd : i_floor_color;
    assign o_last  = r_olast;
endmodule
`default_nettype wire

/* rtl/raycast_textured_column.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// raycast_textured_column
// Textured raycaster wall column renderer.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall) carries load, start and tick words.
// Load words write one texel into a 16K x 24 texture memory, one per cycle
// while input is not stalled. A start word stalls input through two serial
// divisions (wall height, then texture step unless the height is zero) on
// one shared restoring divider and through the setup states. Tick words then
// produce one pixel each, top row first, through an output register; a tick
// is taken every cycle while the output is not stalled, its pixel following
// in the next cycle. A stalled output holds its word and stalls the ticks
// behind it. The user must see that colors are written over the APB port
// only while idle; the block does not enforce it. Reset clears the
// controller, row, bounds, step, output valid, colors; not texture memory.
// ----------------------------------------------------------------------------
module raycast_textured_column #(
    parameter int SCREEN_HEIGHT = 512,
    parameter int SCREEN_WIDTH  = 1024,
    parameter int TEX_SIZE      = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [$clog2(SCREEN_WIDTH)-1:0] i_column,
    input  wire logic [15:0] i_distance,
    input  wire logic signed [15:0] i_ray_x,
    input  wire logic signed [15:0] i_ray_y,
    input  wire logic [15:0] i_pos_x,
    input  wire logic [15:0] i_pos_y,
    input  wire logic        i_side,
    input  wire logic [1:0]  i_tex_select,
    input  wire logic [11:0] i_tex_addr,
    input  wire logic [23:0] i_texel,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [8:0]       o_row,
    output logic [$clog2(SCREEN_WIDTH)-1:0] o_pixel_column,
    output logic [23:0]      o_color,
    output logic             o_last
);
    import rtc_pkg::*;

    logic [23:0] r_ceil, r_floor;
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_out_free;
    logic [9:0] w_pcol;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceil <= '0; r_floor <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_CEIL[0]) r_ceil <= pwdata[23:0];
            else                         r_floor <= pwdata[23:0];
        end
    end
    assign prdata = {8'd0, (paddr[2] == REG_FLOOR[0]) ? r_floor : r_ceil};

    rtc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_valid),
        .i_action(i_action), .i_status(w_status), .i_out_free(w_out_free),
        .o_in_stall(o_stall), .o_cmd(w_cmd)
    );

    rtc_dp #(.SCREEN_HEIGHT(SCREEN_HEIGHT), .TEX_SIZE(TEX_SIZE)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_in_accept(i_valid && !o_stall), .i_action(i_action),
        .i_column(10'(i_column)), .i_distance(i_distance),
        .i_ray_x(i_ray_x), .i_ray_y(i_ray_y), .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y), .i_side(i_side), .i_tex_select(i_tex_select),
        .i_tex_addr(i_tex_addr), .i_texel(i_texel),
        .i_ceiling_color(r_ceil), .i_floor_color(r_floor),
        .i_out_stall(i_stall), .o_status(w_status), .o_out_free(w_out_free),
        .o_out_valid(o_valid), .o_row(o_row), .o_pixel_column(w_pcol),
        .o_color(o_color), .o_last(o_last)
    );
    assign o_pixel_column = w_pcol[$clog2(SCREEN_WIDTH)-1:0];

    a_tick_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.tick |-> w_out_free) else $error("tick without output room");
    a_setup_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.setup || w_cmd.pos) |-> o_stall) else $error("accept during setup");
    a_out_valid_follows_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.tick |=> o_valid) else $error("tick lost");
endmodule
`default_nettype wire
